### rtl/smg_pkg.sv
// ----------------------------------------------------------------------------
// smg_pkg
// Shared types, constants and helper functions of the sphere mesh generator.
// ----------------------------------------------------------------------------
package smg_pkg;

    localparam int CORD_W = 34;
    localparam int ANG_W  = 33;
    localparam int PROD_W = 2 * CORD_W;

    localparam logic signed [CORD_W-1:0] CORDIC_X0 = 34'sd652032874;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_SLICES = 2'd1;
    localparam logic [1:0] REG_STACKS = 2'd2;

    typedef logic signed [CORD_W-1:0] cord_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    function automatic logic [29:0] atan_turn(input logic [4:0] k);
        logic [29:0] v;
        unique case (k)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // Round half up from a Q8.60 product back to Q4.30.
    function automatic cord_t round30(input prod_t p);
        prod_t t;
        t = (p + prod_t'(64'sd536870912)) >>> 30;
        return t[CORD_W-1:0];
    endfunction

    // Radius times factor, rounded to Q9.8 and saturated.
    function automatic logic [16:0] to_pos(input prod_t p);
        prod_t t;
        logic [16:0] r;
        t = (p + prod_t'(64'sd536870912)) >>> 30;
        if (t > prod_t'(65535)) begin
            r = 17'sd65535;
        end
        else if (t < -prod_t'(65535)) begin
            r = -17'sd65535;
        end
        else begin
            r = t[16:0];
        end
        return r;
    endfunction

    function automatic logic [15:0] to_norm(input cord_t q);
        cord_t t;
        logic [15:0] r;
        t = (q + cord_t'(16384)) >>> 15;
        if (t > cord_t'(32767)) begin
            r = 16'sd32767;
        end
        else if (t < -cord_t'(32767)) begin
            r = -16'sd32767;
        end
        else begin
            r = t[15:0];
        end
        return r;
    endfunction

endpackage

### rtl/sphere_mesh_generator.sv
// Each transaction yields at most one result. A ring vertex passes twice
// through the shared divider and twice through the shared CORDIC unit,
// then through the multiply states. Poles and triangles go straight to the
// output. One transaction is in work at a time.
// Reset clears the sequencer and loads the default radius, slice and stack
// counts; there is no clearing pass.
// ----------------------------------------------------------------------------
// sphere_mesh_generator
// UV sphere vertex and triangle generator with a shared divider and CORDIC.
// ----------------------------------------------------------------------------
module sphere_mesh_generator
    import smg_pkg::*;
#(
    parameter int MAX_SLICES   = 255,
    parameter int MAX_STACKS   = 255,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        restart,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        item_kind,
    output logic signed [16:0] pos_x,
    output logic signed [16:0] pos_y,
    output logic signed [16:0] pos_z,
    output logic signed [15:0] norm_x,
    output logic signed [15:0] norm_y,
    output logic signed [15:0] norm_z,
    output logic [16:0] tex_u,
    output logic [16:0] tex_v,
    output logic [15:0] index_a,
    output logic [15:0] index_b,
    output logic [15:0] index_c
);
    localparam int SW = $clog2(MAX_SLICES + 2);
    localparam int TW = $clog2(MAX_STACKS + 1);
    localparam int NW = (SW > TW) ? SW : TW;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_TOP     = 3'd1;
    localparam logic [2:0] PH_RING    = 3'd2;
    localparam logic [2:0] PH_BOTTOM  = 3'd3;
    localparam logic [2:0] PH_CAP_TOP = 3'd4;
    localparam logic [2:0] PH_MID     = 3'd5;
    localparam logic [2:0] PH_CAP_BOT = 3'd6;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_DIV1 = 4'd2;
    localparam logic [3:0] S_DIV2 = 4'd3;
    localparam logic [3:0] S_COR1 = 4'd4;
    localparam logic [3:0] S_COR2 = 4'd5;
    localparam logic [3:0] S_M0   = 4'd6;
    localparam logic [3:0] S_M1   = 4'd7;
    localparam logic [3:0] S_M2   = 4'd8;
    localparam logic [3:0] S_M3   = 4'd9;
    localparam logic [3:0] S_M4   = 4'd10;
    localparam logic [3:0] S_M5   = 4'd11;
    localparam logic [3:0] S_EMIT = 4'd12;

    logic [15:0]   radius_reg;
    logic [7:0]    slice_count_reg;
    logic [7:0]    stack_count_reg;
    logic [15:0]   lat_radius_reg;
    logic [SW-1:0] lat_slices_reg;
    logic [TW-1:0] lat_stacks_reg;
    logic [2:0]    phase_reg, phase_next;
    logic [TW-1:0] ring_reg, ring_next;
    logic [SW-1:0] slice_reg, slice_next;
    logic          quad_reg, quad_next;
    logic [15:0]   base_reg, base_next;
    logic [3:0]    st_reg, st_next;

    logic [31:0]   pa_reg;
    logic [31:0]   ang_reg;
    logic [16:0]   texu_reg;
    logic [16:0]   texv_reg;
    cord_t         sp_reg, cp_reg, st_q_reg, ct_reg;
    cord_t         nx_reg, nz_reg;
    prod_t         prod_reg;
    logic [16:0]   px_reg, py_reg, pz_reg;

    logic          out_valid_reg;
    logic          kind_reg;
    logic [16:0]   pos_x_reg, pos_y_reg, pos_z_reg;
    logic [15:0]   norm_x_reg, norm_y_reg, norm_z_reg;
    logic [16:0]   tex_u_reg, tex_v_reg;
    logic [15:0]   idx_a_reg, idx_b_reg, idx_c_reg;

    logic          in_fire;
    logic          emit_fire;
    logic          div_start, div_done;
    logic [NW-1:0] div_num, div_den;
    logic [32:0]   div_q;
    logic          cor_start, cor_done;
    logic [31:0]   cor_angle;
    cord_t         cor_sin, cor_cos;
    cord_t         mul_a, mul_b;
    prod_t         mul_p;
    logic [SW-1:0] slices_clamped;
    logic [TW-1:0] stacks_clamped;
    logic [15:0]   rv;
    logic [15:0]   south;
    logic [15:0]   mid_b, mid_n;

    logic          e_kind;
    logic [16:0]   e_pos_x, e_pos_y, e_pos_z;
    logic [15:0]   e_norm_x, e_norm_y, e_norm_z;
    logic [16:0]   e_tex_u, e_tex_v;
    logic [15:0]   e_a, e_b, e_c;

    assign in_ready  = (st_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign emit_fire = (st_reg == S_EMIT) && (!out_valid_reg || out_ready);

    always_comb begin
        if (slice_count_reg == 8'd0) begin
            slices_clamped = SW'(1);
        end
        else if (int'(slice_count_reg) > MAX_SLICES) begin
            slices_clamped = SW'(MAX_SLICES);
        end
        else begin
            slices_clamped = SW'(slice_count_reg);
        end
        if (stack_count_reg < 8'd2) begin
            stacks_clamped = TW'(2);
        end
        else if (int'(stack_count_reg) > MAX_STACKS) begin
            stacks_clamped = TW'(MAX_STACKS);
        end
        else begin
            stacks_clamped = TW'(stack_count_reg);
        end
    end

    assign rv    = 16'(lat_slices_reg) + 16'd1;
    assign south = 16'(32'(lat_stacks_reg - 1'b1) * 32'(rv) + 32'd1);
    assign mid_b = base_reg + 16'(slice_reg);
    assign mid_n = mid_b + rv;

    // Shared arithmetic units.
    assign div_start = ((st_reg == S_DISP) && (phase_reg == PH_RING))
                    || ((st_reg == S_DIV1) && div_done);
    assign div_num   = (st_reg == S_DISP) ? NW'(ring_reg) : NW'(slice_reg);
    assign div_den   = (st_reg == S_DISP) ? NW'(lat_stacks_reg) : NW'(lat_slices_reg);

    smg_div #(
        .NUM_W (NW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

    assign cor_start = ((st_reg == S_DIV2) && div_done) || ((st_reg == S_COR1) && cor_done);
    assign cor_angle = (st_reg == S_DIV2) ? pa_reg : ang_reg;

    smg_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .angle (cor_angle),
        .done  (cor_done),
        .sin_q (cor_sin),
        .cos_q (cor_cos)
    );

    always_comb begin
        unique case (st_reg)
            S_M0:    mul_a = sp_reg;
            S_M1:    mul_a = sp_reg;
            S_M2:    mul_a = nx_reg;
            S_M3:    mul_a = cp_reg;
            default: mul_a = nz_reg;
        endcase
        unique case (st_reg)
            S_M0:    mul_b = ct_reg;
            S_M1:    mul_b = st_q_reg;
            default: mul_b = cord_t'({18'd0, lat_radius_reg});
        endcase
    end
    assign mul_p = mul_a * mul_b;

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            S_IDLE: if (in_fire) st_next = S_DISP;
            S_DISP: begin
                if (phase_reg == PH_IDLE) begin
                    st_next = S_IDLE;
                end
                else if (phase_reg == PH_RING) begin
                    st_next = S_DIV1;
                end
                else begin
                    st_next = S_EMIT;
                end
            end
            S_DIV1: if (div_done) st_next = S_DIV2;
            S_DIV2: if (div_done) st_next = S_COR1;
            S_COR1: if (cor_done) st_next = S_COR2;
            S_COR2: if (cor_done) st_next = S_M0;
            S_M0:   st_next = S_M1;
            S_M1:   st_next = S_M2;
            S_M2:   st_next = S_M3;
            S_M3:   st_next = S_M4;
            S_M4:   st_next = S_M5;
            S_M5:   st_next = S_EMIT;
            S_EMIT: if (emit_fire) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_comb begin
        e_kind     = 1'b0;
        e_pos_x    = '0;
        e_pos_y    = '0;
        e_pos_z    = '0;
        e_norm_x   = '0;
        e_norm_y   = '0;
        e_norm_z   = '0;
        e_tex_u    = '0;
        e_tex_v    = '0;
        e_a        = '0;
        e_b        = '0;
        e_c        = '0;
        phase_next = phase_reg;
        ring_next  = ring_reg;
        slice_next = slice_reg;
        quad_next  = quad_reg;
        base_next  = base_reg;
        unique case (phase_reg)
            PH_TOP: begin
                e_pos_y    = {1'b0, lat_radius_reg};
                e_norm_y   = 16'sd32767;
                phase_next = PH_RING;
                ring_next  = TW'(1);
                slice_next = '0;
            end
            PH_RING: begin
                e_pos_x    = px_reg;
                e_pos_y    = py_reg;
                e_pos_z    = pz_reg;
                e_norm_x   = to_norm(nx_reg);
                e_norm_y   = to_norm(cp_reg);
                e_norm_z   = to_norm(nz_reg);
                e_tex_u    = texu_reg;
                e_tex_v    = texv_reg;
                slice_next = slice_reg + 1'b1;
                if (slice_reg + 1'b1 > lat_slices_reg) begin
                    slice_next = '0;
                    ring_next  = ring_reg + 1'b1;
                    if (ring_reg + 1'b1 > lat_stacks_reg - 1'b1) begin
                        phase_next = PH_BOTTOM;
                    end
                end
            end
            PH_BOTTOM: begin
                e_pos_y    = -{1'b0, lat_radius_reg};
                e_norm_y   = -16'sd32767;
                e_tex_v    = 17'd65536;
                phase_next = PH_CAP_TOP;
                slice_next = SW'(1);
            end
            PH_CAP_TOP: begin
                e_kind     = 1'b1;
                e_a        = '0;
                e_b        = 16'(slice_reg) + 16'd1;
                e_c        = 16'(slice_reg);
                slice_next = slice_reg + 1'b1;
                if (slice_reg + 1'b1 > lat_slices_reg) begin
                    slice_next = '0;
                    quad_next  = 1'b0;
                    ring_next  = '0;
                    if (lat_stacks_reg > TW'(2)) begin
                        phase_next = PH_MID;
                        base_next  = 16'd1;
                    end
                    else begin
                        phase_next = PH_CAP_BOT;
                        base_next  = south - rv;
                    end
                end
            end
            PH_MID: begin
                e_kind = 1'b1;
                if (!quad_reg) begin
                    e_a       = mid_b;
                    e_b       = mid_b + 16'd1;
                    e_c       = mid_n;
                    quad_next = 1'b1;
                end
                else begin
                    e_a        = mid_n;
                    e_b        = mid_b + 16'd1;
                    e_c        = mid_n + 16'd1;
                    quad_next  = 1'b0;
                    slice_next = slice_reg + 1'b1;
                    if (slice_reg + 1'b1 >= lat_slices_reg) begin
                        slice_next = '0;
                        base_next  = base_reg + rv;
                        ring_next  = ring_reg + 1'b1;
                        if (ring_reg + 1'b1 >= lat_stacks_reg - TW'(2)) begin
                            phase_next = PH_CAP_BOT;
                            base_next  = south - rv;
                        end
                    end
                end
            end
            PH_CAP_BOT: begin
                e_kind     = 1'b1;
                e_a        = south;
                e_b        = mid_b;
                e_c        = mid_b + 16'd1;
                slice_next = slice_reg + 1'b1;
                if (slice_reg + 1'b1 >= lat_slices_reg) begin
                    phase_next = PH_IDLE;
                    slice_next = '0;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            radius_reg      <= 16'd256;
            slice_count_reg <= 8'd16;
            stack_count_reg <= 8'd16;
            lat_radius_reg  <= '0;
            lat_slices_reg  <= '0;
            lat_stacks_reg  <= '0;
            phase_reg       <= PH_IDLE;
            ring_reg        <= '0;
            slice_reg       <= '0;
            quad_reg        <= 1'b0;
            base_reg        <= '0;
            st_reg          <= S_IDLE;
            out_valid_reg   <= 1'b0;
        end
        else begin
            st_reg <= st_next;
            if (cfg_en) begin
                unique case (cfg_index)
                    REG_RADIUS: radius_reg      <= cfg_data;
                    REG_SLICES: slice_count_reg <= cfg_data[7:0];
                    REG_STACKS: stack_count_reg <= cfg_data[7:0];
                    default:    ;
                endcase
            end
            if (in_fire && restart) begin
                lat_radius_reg <= radius_reg;
                lat_slices_reg <= slices_clamped;
                lat_stacks_reg <= stacks_clamped;
                phase_reg      <= PH_TOP;
            end
            if (emit_fire) begin
                phase_reg     <= phase_next;
                ring_reg      <= ring_next;
                slice_reg     <= slice_next;
                quad_reg      <= quad_next;
                base_reg      <= base_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if ((st_reg == S_DIV1) && div_done) begin
            pa_reg   <= div_q[32:1];
            texv_reg <= div_q[32:16];
        end
        if ((st_reg == S_DIV2) && div_done) begin
            ang_reg  <= div_q[31:0];
            texu_reg <= div_q[32:16];
        end
        if ((st_reg == S_COR1) && cor_done) begin
            sp_reg <= cor_sin;
            cp_reg <= cor_cos;
        end
        if ((st_reg == S_COR2) && cor_done) begin
            st_q_reg <= cor_sin;
            ct_reg   <= cor_cos;
        end
        if ((st_reg >= S_M0) && (st_reg <= S_M4)) begin
            prod_reg <= mul_p;
        end
        if (st_reg == S_M1) nx_reg <= round30(prod_reg);
        if (st_reg == S_M2) nz_reg <= round30(prod_reg);
        if (st_reg == S_M3) px_reg <= to_pos(prod_reg);
        if (st_reg == S_M4) py_reg <= to_pos(prod_reg);
        if (st_reg == S_M5) pz_reg <= to_pos(prod_reg);
        if (emit_fire) begin
            kind_reg   <= e_kind;
            pos_x_reg  <= e_pos_x;
            pos_y_reg  <= e_pos_y;
            pos_z_reg  <= e_pos_z;
            norm_x_reg <= e_norm_x;
            norm_y_reg <= e_norm_y;
            norm_z_reg <= e_norm_z;
            tex_u_reg  <= e_tex_u;
            tex_v_reg  <= e_tex_v;
            idx_a_reg  <= e_a;
            idx_b_reg  <= e_b;
            idx_c_reg  <= e_c;
        end
    end

    assign out_valid = out_valid_reg;
    assign item_kind = kind_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign pos_z     = pos_z_reg;
    assign norm_x    = norm_x_reg;
    assign norm_y    = norm_y_reg;
    assign norm_z    = norm_z_reg;
    assign tex_u     = tex_u_reg;
    assign tex_v     = tex_v_reg;
    assign index_a   = idx_a_reg;
    assign index_b   = idx_b_reg;
    assign index_c   = idx_c_reg;

endmodule

### rtl/smg_div.sv
// ----------------------------------------------------------------------------
// smg_div
// Restoring divider, one quotient bit per cycle: (num << 32) / den.
// ----------------------------------------------------------------------------
module smg_div #(
    parameter int NUM_W = 9
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [NUM_W-1:0] den,
    output logic             done,
    output logic [32:0]      quot
);
    localparam int DIV_BITS = NUM_W + 32;
    localparam int CNT_W    = $clog2(DIV_BITS + 1);

    logic [DIV_BITS-1:0] dvd_reg;
    logic [NUM_W-1:0]    rem_reg;
    logic [NUM_W-1:0]    den_reg;
    logic [32:0]         quo_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [NUM_W:0]      trial;
    logic                ge;
    logic [NUM_W:0]      diff;

    assign trial = {rem_reg, dvd_reg[DIV_BITS-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};
    assign done  = done_reg;
    assign quot  = quo_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_BITS);
            end
            else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            dvd_reg <= {num, 32'd0};
            rem_reg <= '0;
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DIV_BITS-2:0], 1'b0};
            rem_reg <= ge ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
            quo_reg <= {quo_reg[31:0], ge};
        end
    end

endmodule

### rtl/smg_cordic.sv
// ----------------------------------------------------------------------------
// smg_cordic
// Iterative rotation CORDIC, one micro-rotation per cycle, angle in turns.
// ----------------------------------------------------------------------------
module smg_cordic
    import smg_pkg::*;
#(
    parameter int STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] angle,
    output logic        done,
    output cord_t       sin_q,
    output cord_t       cos_q
);
    logic                    busy_reg;
    logic                    done_reg;
    logic [4:0]              k_reg;
    logic                    flip_reg;
    cord_t                   x_reg;
    cord_t                   y_reg;
    logic signed [ANG_W-1:0] z_reg;
    logic                    flip;
    logic [31:0]             folded;
    cord_t                   dx;
    cord_t                   dy;
    logic signed [ANG_W-1:0] at;

    assign flip   = angle[31] ^ angle[30];
    assign folded = flip ? (angle ^ 32'h8000_0000) : angle;
    assign dx     = y_reg >>> k_reg;
    assign dy     = x_reg >>> k_reg;
    assign at     = $signed({3'b000, atan_turn(k_reg)});
    assign done   = done_reg;
    assign sin_q  = flip_reg ? -y_reg : y_reg;
    assign cos_q  = flip_reg ? -x_reg : x_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                k_reg    <= '0;
            end
            else if (busy_reg) begin
                k_reg <= k_reg + 1'b1;
                if (k_reg == 5'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            flip_reg <= flip;
            x_reg    <= CORDIC_X0;
            y_reg    <= '0;
            z_reg    <= ANG_W'($signed(folded));
        end
        else if (busy_reg) begin
            if (!z_reg[ANG_W-1]) begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end
            else begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
        end
    end

endmodule

### rtl/smg_checker.sv
// ----------------------------------------------------------------------------
// smg_checker
// Port-level checks of the sphere mesh generator, bound to the top level.
// ----------------------------------------------------------------------------
module smg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        item_kind,
    input logic [16:0] pos_x,
    input logic [15:0] norm_y,
    input logic [16:0] tex_v,
    input logic [15:0] index_a,
    input logic [15:0] index_b,
    input logic [15:0] index_c
);

    // A stalled result transaction stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // The block works on one transaction at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && item_kind |-> pos_x == 17'd0 && norm_y == 16'd0 && tex_v == 17'd0)
        else $error("triangle carries vertex data");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !item_kind |-> index_a == 16'd0 && index_b == 16'd0 && index_c == 16'd0)
        else $error("vertex carries indices");

endmodule

bind sphere_mesh_generator smg_checker u_smg_checker (.*);

### tb/sphere_mesh_generator_tb.sv
// ----------------------------------------------------------------------------
// sphere_mesh_generator_tb
// Self-checking bench for the UV sphere mesh generator. Tick transactions are
// driven from a queue with random gaps, results are taken with random stalls,
// and every accepted result is compared with a bit-exact in-bench model of the
// vertex and triangle sequence, including the CORDIC sine and cosine.
// ----------------------------------------------------------------------------
module sphere_mesh_generator_tb;
    import smg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLICE_LIMIT = 255;
    localparam int STACK_LIMIT = 255;
    localparam int ROT_STEPS   = 16;
    localparam int ITEM_GOAL   = 1450;
    localparam int SETTLE      = 160;
    localparam longint CYCLE_LIMIT = 1500000;

    typedef enum int {
        GEN_IDLE, GEN_TOP, GEN_RING, GEN_BOTTOM, GEN_CAP_TOP, GEN_MID, GEN_CAP_BOT
    } gen_phase_e;

    typedef struct {
        logic        kind;
        logic [16:0] px, py, pz;
        logic [15:0] nx, ny, nz;
        logic [16:0] u, v;
        logic [15:0] ia, ib, ic;
    } mesh_item_t;

    localparam longint ATAN_TURNS [ROT_STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_en = 1'b0;
    logic [1:0]  cfg_index = REG_RADIUS;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        restart = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        item_kind;
    logic signed [16:0] pos_x, pos_y, pos_z;
    logic signed [15:0] norm_x, norm_y, norm_z;
    logic [16:0] tex_u, tex_v;
    logic [15:0] index_a, index_b, index_c;

    sphere_mesh_generator dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .restart(restart),
        .out_valid(out_valid), .out_ready(out_ready), .item_kind(item_kind),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
        .tex_u(tex_u), .tex_v(tex_v),
        .index_a(index_a), .index_b(index_b), .index_c(index_c)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Register copies and the latched mesh shape of the model.
    logic [15:0] reg_radius = 16'd256;
    logic [7:0]  reg_slices = 8'd16;
    logic [7:0]  reg_stacks = 8'd16;
    int unsigned mesh_radius = 0, mesh_slices = 0, mesh_stacks = 0;
    gen_phase_e  gen_phase = GEN_IDLE;
    int unsigned ring_no = 0, slice_no = 0, quad_half = 0, ring_base = 0;

    bit          tick_queue[$];
    mesh_item_t  expected_items[$];
    longint      sent_count = 0, accepted_count = 0, cycles = 0;
    int          errors = 0, vertex_count = 0, triangle_count = 0, mesh_count = 0;
    int          in_gap = 0, out_stall = 0;
    bit          in_calm = 0, out_calm = 0;

    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    task automatic rotate_turn(input logic [31:0] a, output longint s, output longint c);
        logic [31:0] r;
        longint x, y, z, dx, dy;
        bit flip;
        flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
        r = flip ? (a ^ 32'h8000_0000) : a;
        z = longint'($signed(r));
        x = 652032874;
        y = 0;
        for (int k = 0; k < ROT_STEPS; k++)
        begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= ATAN_TURNS[k];
            end
            else
            begin
                x += dx; y -= dy; z += ATAN_TURNS[k];
            end
        end
        if (flip)
        begin
            x = -x; y = -y;
        end
        s = y;
        c = x;
    endtask

    function automatic longint scale30(longint a, longint b);
        return (a * b + 64'sd536870912) >>> 30;
    endfunction

    function automatic logic [16:0] position_of(longint q);
        longint t;
        t = (q * longint'(mesh_radius) + 64'sd536870912) >>> 30;
        if (t > 65535) t = 65535;
        if (t < -65535) t = -65535;
        return t[16:0];
    endfunction

    function automatic logic [15:0] normal_of(longint q);
        longint t;
        t = (q + 16384) >>> 15;
        if (t > 32767) t = 32767;
        if (t < -32767) t = -32767;
        return t[15:0];
    endfunction

    task automatic ring_vertex(input int unsigned i, input int unsigned j,
                               inout mesh_item_t it);
        logic [31:0] polar, azim;
        longint sp, cp, st, ct, vx, vz;
        polar = 32'((64'(i) << 31) / mesh_stacks);
        azim  = 32'((64'(j) << 32) / mesh_slices);
        rotate_turn(polar, sp, cp);
        rotate_turn(azim, st, ct);
        vx = scale30(sp, ct);
        vz = scale30(sp, st);
        it.px = position_of(vx);
        it.py = position_of(cp);
        it.pz = position_of(vz);
        it.nx = normal_of(vx);
        it.ny = normal_of(cp);
        it.nz = normal_of(vz);
        it.u  = 17'((64'(j) << 16) / mesh_slices);
        it.v  = 17'((64'(i) << 16) / mesh_stacks);
    endtask

    function automatic void triangle(inout mesh_item_t it, input int unsigned a,
                                     input int unsigned b, input int unsigned c);
        it.kind = 1'b1;
        it.ia = 16'(a);
        it.ib = 16'(b);
        it.ic = 16'(c);
    endfunction

    task automatic mesh_tick(input bit rs);
        mesh_item_t it;
        int unsigned rv, south, b, n;
        if (rs)
        begin
            mesh_radius = reg_radius;
            mesh_slices = (reg_slices < 1) ? 1 : (reg_slices > SLICE_LIMIT ? SLICE_LIMIT : reg_slices);
            mesh_stacks = (reg_stacks < 2) ? 2 : (reg_stacks > STACK_LIMIT ? STACK_LIMIT : reg_stacks);
            gen_phase = GEN_TOP;
        end
        if (gen_phase == GEN_IDLE || mesh_slices == 0)
            return;
        it = '{default: '0};
        rv = mesh_slices + 1;
        south = 1 + (mesh_stacks - 1) * rv;
        case (gen_phase)
            GEN_TOP:
            begin
                it.py = 17'(mesh_radius);
                it.ny = 16'sd32767;
                gen_phase = GEN_RING; ring_no = 1; slice_no = 0;
            end
            GEN_RING:
            begin
                ring_vertex(ring_no, slice_no, it);
                if (++slice_no > mesh_slices)
                begin
                    slice_no = 0;
                    if (++ring_no > mesh_stacks - 1) gen_phase = GEN_BOTTOM;
                end
            end
            GEN_BOTTOM:
            begin
                it.py = 17'(-longint'(mesh_radius));
                it.ny = -16'sd32767;
                it.v  = 17'd65536;
                gen_phase = GEN_CAP_TOP; slice_no = 1;
            end
            GEN_CAP_TOP:
            begin
                triangle(it, 0, slice_no + 1, slice_no);
                if (++slice_no > mesh_slices)
                begin
                    slice_no = 0; quad_half = 0; ring_no = 0;
                    if (mesh_stacks > 2)
                    begin
                        gen_phase = GEN_MID; ring_base = 1;
                    end
                    else
                    begin
                        gen_phase = GEN_CAP_BOT; ring_base = (south - rv) & 16'hFFFF;
                    end
                end
            end
            GEN_MID:
            begin
                b = ring_base + slice_no;
                n = b + rv;
                if (quad_half == 0)
                begin
                    triangle(it, b, b + 1, n);
                    quad_half = 1;
                end
                else
                begin
                    triangle(it, n, b + 1, n + 1);
                    quad_half = 0;
                    if (++slice_no >= mesh_slices)
                    begin
                        slice_no = 0;
                        ring_base = (ring_base + rv) & 16'hFFFF;
                        if (++ring_no >= mesh_stacks - 2)
                        begin
                            gen_phase = GEN_CAP_BOT;
                            ring_base = (south - rv) & 16'hFFFF;
                        end
                    end
                end
            end
            default:
            begin
                triangle(it, south, ring_base + slice_no, ring_base + slice_no + 1);
                if (++slice_no >= mesh_slices)
                begin
                    gen_phase = GEN_IDLE; slice_no = 0;
                end
            end
        endcase
        expected_items = {expected_items, it};
    endtask

    // Driver: one tick transaction at a time, launched at the falling edge.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || accepted_count == sent_count))
        begin
            if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (tick_queue.size() > 0)
            begin
                restart <= tick_queue.pop_front();
                in_valid <= 1'b1;
                sent_count <= sent_count + 1;
                in_gap <= pick_gap(in_calm);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_stall > 0)
            begin
                out_stall <= out_stall - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                out_stall <= pick_gap(out_calm);
            end
        end
    end

    always @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            accepted_count <= accepted_count + 1;
            mesh_tick(restart);
        end
    end

    task automatic check_field(input string name, input logic [16:0] exp,
                               input logic [16:0] act);
        if (exp !== act)
        begin
            $error("%s: expected %0h, got %0h", name, exp, act);
            errors++;
        end
    endtask

    // Monitor: compares each result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        mesh_item_t e;
        if (out_valid && out_ready)
        begin
            if (expected_items.size() == 0)
            begin
                $error("result transaction with no expectation pending");
                errors++;
            end
            else
            begin
                e = expected_items.pop_front();
                check_field("item_kind", e.kind, item_kind);
                check_field("pos_x", e.px, pos_x);
                check_field("pos_y", e.py, pos_y);
                check_field("pos_z", e.pz, pos_z);
                check_field("norm_x", e.nx, $unsigned(norm_x));
                check_field("norm_y", e.ny, $unsigned(norm_y));
                check_field("norm_z", e.nz, $unsigned(norm_z));
                check_field("tex_u", e.u, tex_u);
                check_field("tex_v", e.v, tex_v);
                check_field("index_a", e.ia, index_a);
                check_field("index_b", e.ib, index_b);
                check_field("index_c", e.ic, index_c);
                if (e.kind)
                    triangle_count++;
                else
                    vertex_count++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("run timed out after %0d cycles", cycles);
            $display("sphere_mesh_generator_tb: errors");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        @(negedge clk);
        cfg_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        if (idx == REG_RADIUS)
            reg_radius = data;
        else if (idx == REG_SLICES)
            reg_slices = data[7:0];
        else if (idx == REG_STACKS)
            reg_stacks = data[7:0];
        @(negedge clk);
        cfg_en <= 1'b0;
    endtask

    task automatic drain();
        while (tick_queue.size() > 0 || in_valid || expected_items.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic configure(input logic [15:0] r, input logic [15:0] s,
                             input logic [15:0] t);
        write_reg(REG_RADIUS, r);
        write_reg(REG_SLICES, s);
        write_reg(REG_STACKS, t);
    endtask

    function automatic int mesh_length();
        int s, t;
        s = (reg_slices < 1) ? 1 : reg_slices;
        t = (reg_stacks < 2) ? 2 : reg_stacks;
        return 2 + (t - 1) * (s + 1) + 2 * s + 2 * s * (t - 2);
    endfunction

    // Queue one restart followed by plain ticks.
    task automatic queue_mesh(input int ticks);
        tick_queue = {tick_queue, 1'b1};
        repeat (ticks) tick_queue = {tick_queue, 1'b0};
        mesh_count++;
    endtask

    initial
    begin
        int items, len, cut;
        items = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // Ticks before any mesh was started produce nothing.
        tick_queue = {tick_queue, 1'b0};
        tick_queue = {tick_queue, 1'b0};
        drain();

        // Zero radius with slice and stack counts below their minimum.
        configure(16'd0, 16'd0, 16'd0);
        queue_mesh(6);
        drain();

        // Largest radius and counts, cut short; unused register index too.
        configure(16'hFFFF, 16'd255, 16'd255);
        write_reg(2'd3, 16'h5A5A);
        queue_mesh(3);
        drain();

        // Smallest nonzero radius, full mesh with an inner stack.
        configure(16'd1, 16'd2, 16'd3);
        queue_mesh(15);
        drain();
        items = 30;

        while (items < ITEM_GOAL)
        begin
            in_calm = ($urandom_range(0, 3) == 0);
            out_calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                configure($urandom_range(0, 1) ? 16'hFFFF : 16'(($urandom_range(0, 1) << 15) | 1),
                          16'($urandom_range(200, 255)), 16'($urandom_range(200, 255)));
                cut = $urandom_range(1, 30);
                queue_mesh(cut);
                items += cut + 1;
            end
            else
            begin
                configure(16'($urandom()), 16'($urandom_range(0, 8)),
                          16'($urandom_range(0, 6)));
                len = mesh_length();
                if ($urandom_range(0, 4) == 0)
                begin
                    cut = $urandom_range(0, len - 1);
                    queue_mesh(cut);
                    items += cut + 1;
                end
                queue_mesh(len - 1 + $urandom_range(0, 3));
                items += len;
            end
            drain();
        end

        $display("covered %0d meshes: %0d vertices and %0d triangles checked",
                 mesh_count, vertex_count, triangle_count);
        $display("%0d tick transactions accepted in %0d cycles", accepted_count, cycles);
        if (errors == 0)
            $display("sphere_mesh_generator_tb: clean");
        else
            $display("sphere_mesh_generator_tb: errors");
        $finish;
    end

endmodule
